// File: design/assert_macros.svh
// Assertion helpers; expect clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define FCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/fca_pkg.sv
package fca_pkg;

  localparam int TABLE_ENTRIES = 2048;
  localparam int CONTENT_BYTES = 4032;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES) + 1;
  localparam int LINK_W  = 16;
  localparam int LEN_W   = 24;

  localparam int SUM_W       = LEN_W + 1;
  localparam int MUL_W       = LEN_W + 2;
  localparam int PROD_W      = SUM_W + MUL_W;
  localparam int RECIP_SHIFT = SUM_W + $clog2(CONTENT_BYTES);

  // reciprocal of CONTENT_BYTES, rounded up; exact for any sum below 2**SUM_W
  localparam logic [MUL_W-1:0] RECIP_MUL =
    MUL_W'(((64'd1 << RECIP_SHIFT) + 64'(CONTENT_BYTES) - 64'd1) / 64'(CONTENT_BYTES));

  localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
  localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;
  localparam int FIRST_USABLE = 2;

  typedef enum logic [1:0] {
    FN_ALLOC  = 2'd0,
    FN_FREE   = 2'd1,
    FN_READ   = 2'd2,
    FN_FORMAT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BAD_START = 2'd2,
    ST_BROKEN    = 2'd3
  } status_e;

  typedef struct packed {
    logic             go;
    logic [LEN_W-1:0] len;
    logic             dir;
  } need_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] need;
  } need_rsp_t;

endpackage

// File: design/fca_ram.sv
module fca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/fca_need.sv
module fca_need (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fca_pkg::need_req_t req_i,
  output fca_pkg::need_rsp_t rsp_o
);
  import fca_pkg::*;

  logic              vld_q;
  logic              done_q;
  logic              dir_q;
  logic [SUM_W-1:0]  sum_q;
  logic [LEN_W-1:0]  need_q, need_d;

  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  quo;

  // ceiling as floor((len + CONTENT_BYTES - 1) / CONTENT_BYTES), the divide
  // done as a multiply by the rounded-up reciprocal
  assign prod = PROD_W'(sum_q) * PROD_W'(RECIP_MUL);
  assign quo  = LEN_W'(prod >> RECIP_SHIFT);

  always_comb begin
    need_d = need_q;
    if (vld_q) begin
      // directory, or an empty file, takes one block
      need_d = (dir_q || quo == '0) ? LEN_W'(1) : quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= req_i.go;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      sum_q <= SUM_W'(req_i.len) + SUM_W'(CONTENT_BYTES - 1);
      dir_q <= req_i.dir;
    end
    need_q <= need_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.need = need_q;

endmodule

// File: design/fat_chain_allocator_core.sv
// Block link table with allocate, free, read and format commands.
// Drive func_i and the operand ports with start high while busy is low;
// the command is taken at that edge. Exactly one result follows: done_o
// is high for one cycle with status_o, first_block_o, block_count_o and
// link_value_o, and it must be taken in that cycle. busy falls as done_o
// rises, so the next command can be issued in the result cycle.
// Steps per command:
//   bad start on read or free: result with no table access; read: one table read.
//   free: one walk of the chain checks each link, a second walk clears it;
//   a free start entry or a broken link ends early.
//   allocate: the block count (reciprocal multiply), a scan counting free
//   entries, a scan linking them, then the chain end is written.
//   no space: ends after the counting scan. format: one table write per cycle.
// One command at a time; the single-port read of the link memory paces
// every scan and walk.
// After reset the table, all 2048 entries, is cleared one entry per cycle with
// busy high; no result is produced for that pass.
// The receiver cannot stall; results are never held.
`include "assert_macros.svh"

module fat_chain_allocator_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func_i,
  input  logic [23:0]           content_length_i,
  input  logic                  is_directory_i,
  input  logic [10:0]           start_block_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [10:0]           first_block_o,
  output logic [11:0]           block_count_o,
  output logic [15:0]           link_value_o
);
  import fca_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_NEED, S_COUNT, S_LINK, S_LINK_END,
    S_FW_RD, S_FW_EV, S_FC_RD, S_FC_EV, S_RD_EV
  } state_e;

  state_e            state_q, state_d;
  logic              fmt_q, fmt_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              rv_q, rv_d;
  logic [IDX_W-1:0]  ridx_q, ridx_d;
  logic [CNT_W-1:0]  avail_q, avail_d;
  logic [LEN_W-1:0]  need_q, need_d;
  logic [CNT_W-1:0]  got_q, got_d;
  logic [IDX_W-1:0]  prev_q, prev_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  origin_q, origin_d;
  logic [CNT_W-1:0]  steps_q, steps_d;
  logic              first_step_q, first_step_d;

  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  logic [10:0]       fblk_q, fblk_d;
  logic [11:0]       count_q, count_d;
  logic [15:0]       link_q, link_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [LINK_W-1:0] ram_rdata;

  need_req_t         need_req;
  need_rsp_t         need_rsp;

  logic              accept;
  logic              scan_end;
  logic              start_oob;
  logic              link_bad;
  logic              nospace_res;

  fca_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fca_need u_need (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (need_req),
    .rsp_o  (need_rsp)
  );

  assign accept    = start && (state_q == S_IDLE);
  assign scan_end  = (scan_q == CNT_W'(TABLE_ENTRIES));
  assign start_oob = 32'(start_block_i) >= 32'(TABLE_ENTRIES);
  assign link_bad  = (ram_rdata == LINK_FREE) ||
                     (32'(ram_rdata) < 32'(FIRST_USABLE)) ||
                     (32'(ram_rdata) >= 32'(TABLE_ENTRIES));

  always_comb begin
    state_d      = state_q;
    fmt_d        = fmt_q;
    scan_d       = scan_q;
    rv_d         = 1'b0;
    ridx_d       = ridx_q;
    avail_d      = avail_q;
    need_d       = need_q;
    got_d        = got_q;
    prev_d       = prev_q;
    head_d       = head_q;
    cur_d        = cur_q;
    origin_d     = origin_q;
    steps_d      = steps_q;
    first_step_d = first_step_q;

    done_d   = 1'b0;
    status_d = status_q;
    fblk_d   = fblk_q;
    count_d  = count_q;
    link_d   = link_q;

    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = LINK_FREE;
    ram_raddr = cur_q;

    need_req.go  = 1'b0;
    need_req.len = content_length_i;
    need_req.dir = is_directory_i;

    // sequential table scan: address now, data next cycle
    if ((state_q == S_COUNT || state_q == S_LINK) && !scan_end) begin
      ram_raddr = scan_q[IDX_W-1:0];
      rv_d      = 1'b1;
      ridx_d    = scan_q[IDX_W-1:0];
      scan_d    = scan_q + CNT_W'(1);
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q[IDX_W-1:0];
        ram_wdata = (32'(scan_q) < 32'(FIRST_USABLE)) ? LINK_END : LINK_FREE;
        scan_d    = scan_q + CNT_W'(1);
        if (scan_q == CNT_W'(TABLE_ENTRIES - 1)) begin
          state_d = S_IDLE;
          if (fmt_q) begin
            done_d   = 1'b1;
            status_d = ST_OK;
            fblk_d   = '0;
            count_d  = '0;
            link_d   = '0;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          fblk_d  = '0;
          count_d = '0;
          link_d  = '0;
          case (func_e'(func_i))
            FN_ALLOC: begin
              need_req.go = 1'b1;
              state_d     = S_NEED;
            end
            FN_FREE: begin
              if (start_oob || 32'(start_block_i) < 32'(FIRST_USABLE)) begin
                done_d   = 1'b1;
                status_d = ST_BAD_START;
              end else begin
                cur_d        = IDX_W'(start_block_i);
                origin_d     = IDX_W'(start_block_i);
                steps_d      = CNT_W'(1);
                first_step_d = 1'b1;
                state_d      = S_FW_RD;
              end
            end
            FN_READ: begin
              if (start_oob) begin
                done_d   = 1'b1;
                status_d = ST_BAD_START;
              end else begin
                ram_raddr = IDX_W'(start_block_i);
                state_d   = S_RD_EV;
              end
            end
            FN_FORMAT: begin
              fmt_d   = 1'b1;
              scan_d  = '0;
              state_d = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_NEED: begin
        if (need_rsp.done) begin
          need_d  = need_rsp.need;
          scan_d  = '0;
          avail_d = '0;
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        if (rv_q && ram_rdata == LINK_FREE) begin
          avail_d = avail_q + CNT_W'(1);
        end
        if (scan_end && !rv_q) begin
          if (LEN_W'(avail_q) < need_q) begin
            done_d   = 1'b1;
            status_d = ST_NO_SPACE;
            state_d  = S_IDLE;
          end else begin
            scan_d  = '0;
            rv_d    = 1'b0;
            got_d   = '0;
            state_d = S_LINK;
          end
        end
      end
      S_LINK: begin
        if (rv_q && ram_rdata == LINK_FREE) begin
          if (got_q == '0) begin
            head_d = ridx_q;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = prev_q;
            ram_wdata = LINK_W'(ridx_q);
          end
          prev_d = ridx_q;
          got_d  = got_q + CNT_W'(1);
          if (LEN_W'(got_q) + LEN_W'(1) == need_q) begin
            state_d = S_LINK_END;
          end
        end
      end
      S_LINK_END: begin
        ram_we    = 1'b1;
        ram_waddr = prev_q;
        ram_wdata = LINK_END;
        done_d    = 1'b1;
        status_d  = ST_OK;
        fblk_d    = 11'(head_q);
        count_d   = 12'(need_q);
        state_d   = S_IDLE;
      end
      S_FW_RD: begin
        state_d = S_FW_EV;
      end
      S_FW_EV: begin
        if (first_step_q && ram_rdata == LINK_FREE) begin
          done_d   = 1'b1;
          status_d = ST_BAD_START;
          state_d  = S_IDLE;
        end else if (ram_rdata == LINK_END) begin
          cur_d   = origin_q;
          state_d = S_FC_RD;
        end else if (link_bad || steps_q == CNT_W'(TABLE_ENTRIES)) begin
          // bad link, or one more step would exceed the table: a loop
          done_d   = 1'b1;
          status_d = ST_BROKEN;
          state_d  = S_IDLE;
        end else begin
          cur_d        = IDX_W'(ram_rdata);
          steps_d      = steps_q + CNT_W'(1);
          first_step_d = 1'b0;
          state_d      = S_FW_RD;
        end
      end
      S_FC_RD: begin
        state_d = S_FC_EV;
      end
      S_FC_EV: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = LINK_FREE;
        if (ram_rdata == LINK_END) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          count_d  = 12'(steps_q);
          state_d  = S_IDLE;
        end else begin
          cur_d   = IDX_W'(ram_rdata);
          state_d = S_FC_RD;
        end
      end
      S_RD_EV: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        link_d   = ram_rdata;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      fmt_q   <= 1'b0;
      scan_q  <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fmt_q   <= fmt_d;
      scan_q  <= scan_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q       <= ridx_d;
    avail_q      <= avail_d;
    need_q       <= need_d;
    got_q        <= got_d;
    prev_q       <= prev_d;
    head_q       <= head_d;
    cur_q        <= cur_d;
    origin_q     <= origin_d;
    steps_q      <= steps_d;
    first_step_q <= first_step_d;
    status_q     <= status_d;
    fblk_q       <= fblk_d;
    count_q      <= count_d;
    link_q       <= link_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign first_block_o = fblk_q;
  assign block_count_o = count_q;
  assign link_value_o  = link_q;

  assign nospace_res = done_o && (status_o == ST_NO_SPACE);

  `FCA_ASSERT_IMP(a_done_idle, done_o, !busy)
  `FCA_ASSERT_NXT(a_accept_busy, start && !busy, busy || done_o)
  `FCA_ASSERT_IMP(a_write_busy, ram_we, busy)
  `FCA_ASSERT_IMP(a_nospace_clean, nospace_res, first_block_o == '0 && block_count_o == '0)

endmodule
